// ===== rtl/core/yrgb_pkg.sv =====
// yrgb_pkg: shared types and constants for the YUYV pair to RGB888 converter.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package yrgb_pkg;

    // Datapath widths
    localparam int CHAN_W   = 8;   // one color or luma/chroma byte
    localparam int PROD_W   = 20;  // signed gain products, max |1164*239| = 278196
    localparam int SUM_W    = 21;  // signed channel sums, max 534482
    localparam int VAL_W    = 18;  // in-range scaled sum, below 256000
    localparam int RECIP_W  = 19;  // width of the 1/1000 reciprocal
    localparam int RECIP_SH = 28;  // reciprocal scale, 2^28
    localparam int N_CHAN   = 6;

    // Channel slots inside a channel set
    localparam int CH_R0 = 0;
    localparam int CH_G0 = 1;
    localparam int CH_B0 = 2;
    localparam int CH_R1 = 3;
    localparam int CH_G1 = 4;
    localparam int CH_B1 = 5;

    // Integer gains, scaled by 1000
    localparam logic signed [PROD_W-1:0] C_LUMA_GAIN = 20'sd1164;
    localparam logic signed [PROD_W-1:0] C_RED_V     = 20'sd1159;
    localparam logic signed [PROD_W-1:0] C_GRN_U     = 20'sd380;
    localparam logic signed [PROD_W-1:0] C_GRN_V     = 20'sd813;
    localparam logic signed [PROD_W-1:0] C_BLU_U     = 20'sd2018;

    localparam logic signed [8:0] C_LUMA_OFS   = 9'sd16;
    localparam logic signed [8:0] C_CHROMA_MID = 9'sd128;

    // Scaled sums at or above 256*1000 clamp to full scale
    localparam logic signed [SUM_W-1:0] C_SAT_LIM = 21'sd256000;
    localparam logic [VAL_W-1:0]        C_VAL_LIM = 18'd256000;

    // ceil(2^28 / 1000): exact floor division for every value below 256000
    localparam logic [RECIP_W-1:0] C_RECIP = 19'd268436;

    localparam logic [CHAN_W-1:0] C_CHAN_MAX = 8'd255;

    // Input word: one YUYV macropixel
    typedef struct packed {
        logic [CHAN_W-1:0] y_first;
        logic [CHAN_W-1:0] u_chroma;
        logic [CHAN_W-1:0] y_second;
        logic [CHAN_W-1:0] v_chroma;
    } t_yuyv;

    // Output word: two RGB888 pixels
    typedef struct packed {
        logic [CHAN_W-1:0] red_first;
        logic [CHAN_W-1:0] green_first;
        logic [CHAN_W-1:0] blue_first;
        logic [CHAN_W-1:0] red_second;
        logic [CHAN_W-1:0] green_second;
        logic [CHAN_W-1:0] blue_second;
    } t_rgb;

    // Gain products of one macropixel
    typedef struct packed {
        logic signed [PROD_W-1:0] base_first;
        logic signed [PROD_W-1:0] base_second;
        logic signed [PROD_W-1:0] red_v;
        logic signed [PROD_W-1:0] grn_u;
        logic signed [PROD_W-1:0] grn_v;
        logic signed [PROD_W-1:0] blu_u;
    } t_prod;

    // Scaled channel sum with its clamp flags
    typedef struct packed {
        logic             zero;
        logic             sat;
        logic [VAL_W-1:0] val;
    } t_chan;

    typedef t_chan [N_CHAN-1:0] t_chan_set;

    // Quotient by 1000 with its clamp flags
    typedef struct packed {
        logic              zero;
        logic              sat;
        logic [CHAN_W-1:0] quo;
    } t_quo;

    typedef t_quo [N_CHAN-1:0] t_quo_set;

endpackage

`default_nettype wire

// ===== rtl/core/yrgb_stream_if.sv =====
// yrgb_stream_if: valid/ready stream channel carrying one word of a given type.
// No dependencies; the word type comes from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

interface yrgb_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/yrgb_mult.sv =====
// yrgb_mult: first pipeline stage, removes the offsets and forms the gain products.
// Depends on yrgb_pkg and yrgb_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_mult (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yrgb_stream_if.sink   i_yuyv,
    yrgb_stream_if.source o_prod
);
    import yrgb_pkg::*;

    logic signed [8:0] y0_off;
    logic signed [8:0] y1_off;
    logic signed [8:0] u_off;
    logic signed [8:0] v_off;
    logic              adv;
    logic              r_valid;
    t_prod             r_prod;
    t_prod             n_prod;

    // Offset removal, all values fit in 9 signed bits
    assign y0_off = $signed({1'b0, i_yuyv.data.y_first})  - C_LUMA_OFS;
    assign y1_off = $signed({1'b0, i_yuyv.data.y_second}) - C_LUMA_OFS;
    assign u_off  = $signed({1'b0, i_yuyv.data.u_chroma}) - C_CHROMA_MID;
    assign v_off  = $signed({1'b0, i_yuyv.data.v_chroma}) - C_CHROMA_MID;

    // One small multiplier per term
    always_comb begin
        n_prod.base_first  = PROD_W'(y0_off) * C_LUMA_GAIN;
        n_prod.base_second = PROD_W'(y1_off) * C_LUMA_GAIN;
        n_prod.red_v       = PROD_W'(v_off)  * C_RED_V;
        n_prod.grn_u       = PROD_W'(u_off)  * C_GRN_U;
        n_prod.grn_v       = PROD_W'(v_off)  * C_GRN_V;
        n_prod.blu_u       = PROD_W'(u_off)  * C_BLU_U;
    end

    // Stage handshake: load when empty or when the next stage drains
    assign i_yuyv.ready = !r_valid || o_prod.ready;
    assign adv          = i_yuyv.valid && i_yuyv.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_yuyv.ready) begin
            r_valid <= i_yuyv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod.valid = r_valid;
    assign o_prod.data  = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/yrgb_sum.sv =====
// yrgb_sum: second pipeline stage, adds luma and chroma terms and flags the clamp cases.
// Depends on yrgb_pkg and yrgb_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_sum (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yrgb_stream_if.sink   i_prod,
    yrgb_stream_if.source o_chan
);
    import yrgb_pkg::*;

    logic signed [SUM_W-1:0] grn_term;
    logic signed [SUM_W-1:0] sums [N_CHAN];
    logic                    adv;
    logic                    r_valid;
    t_chan_set               r_set;
    t_chan_set               n_set;

    // Negative sums clamp to zero; large sums saturate
    function automatic t_chan chan_prep(input logic signed [SUM_W-1:0] sum);
        t_chan c;
        c.zero = sum[SUM_W-1];
        c.sat  = !sum[SUM_W-1] && (sum >= C_SAT_LIM);
        c.val  = sum[VAL_W-1:0];
        return c;
    endfunction

    // Channel sums for both pixels, sharing the chroma terms
    always_comb begin
        grn_term     = SUM_W'(i_prod.data.grn_u) + SUM_W'(i_prod.data.grn_v);
        sums[CH_R0]  = SUM_W'(i_prod.data.base_first)  + SUM_W'(i_prod.data.red_v);
        sums[CH_G0]  = SUM_W'(i_prod.data.base_first)  - grn_term;
        sums[CH_B0]  = SUM_W'(i_prod.data.base_first)  + SUM_W'(i_prod.data.blu_u);
        sums[CH_R1]  = SUM_W'(i_prod.data.base_second) + SUM_W'(i_prod.data.red_v);
        sums[CH_G1]  = SUM_W'(i_prod.data.base_second) - grn_term;
        sums[CH_B1]  = SUM_W'(i_prod.data.base_second) + SUM_W'(i_prod.data.blu_u);
        for (int k = 0; k < N_CHAN; k++) begin
            n_set[k] = chan_prep(sums[k]);
        end
    end

    // Stage handshake
    assign i_prod.ready = !r_valid || o_chan.ready;
    assign adv          = i_prod.valid && i_prod.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_prod.ready) begin
            r_valid <= i_prod.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_set <= n_set;
        end
    end

    assign o_chan.valid = r_valid;
    assign o_chan.data  = r_set;

    // A held channel is either clamped one way or in the divider's exact range
    for (genvar k = 0; k < N_CHAN; k++) begin : g_chk
        a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_valid |-> !(r_set[k].zero && r_set[k].sat))
            else $error("channel flagged both zero and saturated");

        a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && !r_set[k].zero && !r_set[k].sat) |-> (r_set[k].val < C_VAL_LIM))
            else $error("unclamped channel outside divider range");
    end

endmodule

`default_nettype wire

// ===== rtl/core/yrgb_div.sv =====
// yrgb_div: last two pipeline stages, divide by 1000 through a reciprocal, then clamp.
// Depends on yrgb_pkg and yrgb_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yrgb_stream_if.sink   i_chan,
    yrgb_stream_if.source o_rgb
);
    import yrgb_pkg::*;

    localparam int MUL_W = VAL_W + RECIP_W;

    logic [MUL_W-1:0] prod [N_CHAN];
    logic             a_ready;
    logic             b_ready;
    logic             a_adv;
    logic             b_adv;
    logic             r_a_valid;
    logic             r_b_valid;
    t_quo_set         r_a;
    t_quo_set         n_a;
    t_rgb             r_b;
    t_rgb             n_b;

    function automatic logic [CHAN_W-1:0] clamp_quo(input t_quo q);
        logic [CHAN_W-1:0] c;
        priority if (q.zero) begin
            c = '0;
        end else if (q.sat) begin
            c = C_CHAN_MAX;
        end else begin
            c = q.quo;
        end
        return c;
    endfunction

    // Stage A: floor(val / 1000) = (val * recip) >> 28
    always_comb begin
        for (int k = 0; k < N_CHAN; k++) begin
            prod[k]     = MUL_W'(i_chan.data[k].val) * MUL_W'(C_RECIP);
            n_a[k].zero = i_chan.data[k].zero;
            n_a[k].sat  = i_chan.data[k].sat;
            n_a[k].quo  = prod[k][RECIP_SH+CHAN_W-1:RECIP_SH];
        end
    end

    // Stage B: clamp into the output word
    always_comb begin
        n_b.red_first    = clamp_quo(r_a[CH_R0]);
        n_b.green_first  = clamp_quo(r_a[CH_G0]);
        n_b.blue_first   = clamp_quo(r_a[CH_B0]);
        n_b.red_second   = clamp_quo(r_a[CH_R1]);
        n_b.green_second = clamp_quo(r_a[CH_G1]);
        n_b.blue_second  = clamp_quo(r_a[CH_B1]);
    end

    // Handshake for both stages
    assign b_ready      = !r_b_valid || o_rgb.ready;
    assign a_ready      = !r_a_valid || b_ready;
    assign i_chan.ready = a_ready;
    assign a_adv        = i_chan.valid && a_ready;
    assign b_adv        = r_a_valid && b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_chan.valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a <= n_a;
        end
        if (b_adv) begin
            r_b <= n_b;
        end
    end

    assign o_rgb.valid = r_b_valid;
    assign o_rgb.data  = r_b;

    // A word moving out of stage A is presented next cycle, with its clamps applied
    a_b_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_adv |=> r_b_valid)
        else $error("word lost between divider stages");

    a_zero_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_a[CH_R0].zero) |=> (o_rgb.data.red_first == '0))
        else $error("negative red of first pixel not clamped to zero");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_a[CH_B1].sat) |=> (o_rgb.data.blue_second == C_CHAN_MAX))
        else $error("large blue of second pixel not clamped to full scale");

endmodule

`default_nettype wire

// ===== rtl/core/yuyv_pair_to_rgb888.sv =====
// yuyv_pair_to_rgb888: top level, YUYV 4:2:2 macropixel to two RGB888 pixels.
// Depends on yrgb_pkg, yrgb_stream_if, yrgb_mult, yrgb_sum and yrgb_div.
//
//   channel   direction   word     contents
//   i_yuyv    in          t_yuyv   y_first, u_chroma, y_second, v_chroma
//   o_rgb     out         t_rgb    red/green/blue of first and second pixel
//
// One word per clock sustained while o_rgb is ready; each word passes through
// the register stages in order: gain products, channel sums with clamp flags,
// reciprocal multiply by 1/1000, clamp into the output register.
// Reset clears only the stage valid bits; no state is kept between words.
// Each stage loads when it is empty or its successor drains, so a stall on
// o_rgb backs up stage by stage and bubbles are squeezed out.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_pair_to_rgb888 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yrgb_stream_if.sink   i_yuyv,
    yrgb_stream_if.source o_rgb
);
    import yrgb_pkg::*;

    yrgb_stream_if #(.t_word(t_prod))     s_prod ();
    yrgb_stream_if #(.t_word(t_chan_set)) s_chan ();

    // Stage 1: offsets and gain products
    yrgb_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_yuyv  (i_yuyv),
        .o_prod  (s_prod)
    );

    // Stage 2: channel sums and clamp flags
    yrgb_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (s_prod),
        .o_chan  (s_chan)
    );

    // Stages 3 and 4: divide by 1000 and clamp
    yrgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chan  (s_chan),
        .o_rgb   (o_rgb)
    );

endmodule

`default_nettype wire
